// ----- rtl/core/pqrr_pkg.sv -----
`default_nettype none
package pqrr_pkg;

  // Result status codes.
  localparam logic [2:0] ST_QUEUED  = 3'd0;
  localparam logic [2:0] ST_DROPPED = 3'd1;
  localparam logic [2:0] ST_DEQUEUE = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_SAMEHOP = 3'd4;
  localparam logic [2:0] ST_NOSLOT  = 3'd5;

  // Item kinds.
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_LIMIT  = 3'd1;
  localparam logic [2:0] REG_ECN    = 3'd2;
  localparam logic [2:0] REG_FRONT  = 3'd3;
  localparam logic [2:0] REG_HOP    = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_EVAL,
    S_RD1,
    S_RD0,
    S_MOD,
    S_DEQ,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/pqrr_ram.sv -----
`default_nettype none
module pqrr_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pqrr_sel.sv -----
`default_nettype none
module pqrr_sel #(
  parameter int PORTS = 8
) (
  input  wire logic [PORTS-1:0]                          map_valid,
  input  wire logic [PORTS-1:0][15:0]                    map_addr,
  input  wire logic [15:0]                               src,
  input  wire logic [PORTS-1:0]                          nonempty,
  input  wire logic [$clog2(PORTS+1)-1:0]                used,
  input  wire logic [((PORTS > 1) ? $clog2(PORTS) : 1)-1:0] start,
  output logic                                           find_hit,
  output logic [((PORTS > 1) ? $clog2(PORTS) : 1)-1:0]   find_idx,
  output logic                                           pick_hit,
  output logic [((PORTS > 1) ? $clog2(PORTS) : 1)-1:0]   pick_idx
);

  localparam int SW = (PORTS > 1) ? $clog2(PORTS) : 1;

  logic [PORTS-1:0] cand;
  logic [PORTS-1:0] ready;
  logic [PORTS-1:0] upper;
  logic             upper_hit;
  logic [SW-1:0]    upper_idx;
  logic             any_hit;
  logic [SW-1:0]    any_idx;

  // Slot candidates: matching or free slots, and non-empty slots, within the active range.
  always_comb begin
    for (int i = 0; i < PORTS; i++) begin
      cand[i]  = (32'(i) < 32'(used)) &&
                 (!map_valid[i] || (map_addr[i] == src));
      ready[i] = (32'(i) < 32'(used)) && nonempty[i];
      upper[i] = ready[i] && (32'(i) >= 32'(start));
    end
  end

  // Priority encoders: the lowest set bit wins.
  always_comb begin
    find_hit  = 1'b0;
    find_idx  = '0;
    upper_hit = 1'b0;
    upper_idx = '0;
    any_hit   = 1'b0;
    any_idx   = '0;
    for (int i = PORTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        find_hit = 1'b1;
        find_idx = SW'(i);
      end
      if (upper[i]) begin
        upper_hit = 1'b1;
        upper_idx = SW'(i);
      end
      if (ready[i]) begin
        any_hit = 1'b1;
        any_idx = SW'(i);
      end
    end
    pick_hit = any_hit;
    pick_idx = upper_hit ? upper_idx : any_idx;
  end

endmodule
`default_nettype wire

// ----- rtl/core/per_input_queue_round_robin_unit.sv -----
`default_nettype none
// Per-input queue with round-robin service. An enqueue beat binds its source address to a
// slot and appends the handle to that slot's FIFO in the descriptor RAM, marking and
// dropping a victim against the ECN threshold and the queue limit; a dequeue beat pops
// the head of the next non-empty slot in round-robin order. Every item gives exactly one
// result beat. A plain enqueue or a dequeue takes longer than a same-hop, no-slot or empty
// result, a front-mode enqueue whose victim is an older entry takes longer still, and one
// whose victim is dropped takes longest; a dequeue after a shrink of active_ports also makes
// passes of the turn reduction, and a finished result waits for the output register. The
// descriptor RAM has one write port and one registered read port, and a front-mode drop
// needs two reads of it. A new item is taken while the previous result still waits in the
// output register.
module per_input_queue_round_robin_unit #(
  parameter int PORTS      = 8,
  parameter int SLOT_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // source_addr[15:0], handle[31:16]
  input  wire logic [0:0]  in_tuser,   // kind[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_handle[15:0], ce_mark[16], slot[19:17],
                                       // slot_length[26:20], zero[31:27]
  output logic [2:0]       out_tuser,  // status[2:0]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  import pqrr_pkg::*;

  localparam int SW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int NW = $clog2(PORTS + 1);
  localparam int DW = $clog2(SLOT_DEPTH);
  localparam int LW = $clog2(SLOT_DEPTH + 1);
  localparam int AW = $clog2(PORTS * SLOT_DEPTH);

  // Configuration registers.
  logic [3:0]  act_r;
  logic [5:0]  lim_cfg_r;
  logic [5:0]  thr_r;
  logic        front_r;
  logic [15:0] hop_r;

  // Per-slot state.
  logic [PORTS-1:0]       map_valid_r;
  logic [PORTS-1:0][15:0] map_addr_r;
  logic [DW-1:0]          head_r [PORTS];
  logic [LW-1:0]          len_r  [PORTS];
  logic [SW-1:0]          turn_r;

  // Item and sequencer registers.
  state_t        state_r, state_nxt;
  logic [15:0]   src_r;
  logic [15:0]   hd_r;
  logic [SW-1:0] sel_r;
  logic [SW-1:0] start_r;
  logic          mark_r;
  logic          drop_r;
  logic [2:0]    res_status_r;
  logic [15:0]   res_handle_r;
  logic          res_mark_r;
  logic [LW-1:0] res_len_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [15:0]   out_handle_r;
  logic          out_mark_r;
  logic [2:0]    out_slot_r;
  logic [6:0]    out_len_r;

  logic             cfg_wr;
  logic [NW-1:0]    used;
  logic [PORTS-1:0] nonempty;
  logic             find_hit;
  logic [SW-1:0]    find_idx;
  logic             pick_hit;
  logic [SW-1:0]    pick_idx;
  logic [SW-1:0]    idx_w;
  logic [DW-1:0]    head_w;
  logic [DW-1:0]    head_inc;
  logic [LW-1:0]    len_w;
  logic [11:0]      lim_w;
  logic             markc;
  logic             drop;
  logic             victim_new;
  logic [AW-1:0]    addr0, addr1, addr_l;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [16:0]      wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [16:0]      rd_data;
  logic [16:0]      e1;
  logic             accept;
  logic             load_out;

  // Address of logical entry k of slot s whose head sits at h.
  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                              input logic [DW-1:0] h,
                                              input logic [DW-1:0] k);
    logic [DW:0] off;
    begin
      off = {1'b0, h} + {1'b0, k};
      if (off >= (DW + 1)'(SLOT_DEPTH)) begin
        off = off - (DW + 1)'(SLOT_DEPTH);
      end
      slot_addr = AW'(s) * AW'(SLOT_DEPTH) + AW'(off);
    end
  endfunction

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 4'd8;
      lim_cfg_r <= 6'd63;
      thr_r     <= 6'd0;
      front_r   <= 1'b0;
      hop_r     <= 16'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_ACTIVE: act_r     <= cfg_pwdata[3:0];
        REG_LIMIT:  lim_cfg_r <= cfg_pwdata[5:0];
        REG_ECN:    thr_r     <= cfg_pwdata[5:0];
        REG_FRONT:  front_r   <= cfg_pwdata[0];
        REG_HOP:    hop_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_ACTIVE: cfg_prdata = {28'd0, act_r};
      REG_LIMIT:  cfg_prdata = {26'd0, lim_cfg_r};
      REG_ECN:    cfg_prdata = {26'd0, thr_r};
      REG_FRONT:  cfg_prdata = {31'd0, front_r};
      REG_HOP:    cfg_prdata = {16'd0, hop_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // Number of slots in use and the effective queue limit.
  always_comb begin
    if (act_r == 4'd0) begin
      used = NW'(1);
    end else if (32'(act_r) > PORTS) begin
      used = NW'(PORTS);
    end else begin
      used = NW'(act_r);
    end
    if (32'(lim_cfg_r) > SLOT_DEPTH - 1) begin
      lim_w = 12'(SLOT_DEPTH - 1);
    end else begin
      lim_w = 12'(lim_cfg_r);
    end
  end

  always_comb begin
    for (int i = 0; i < PORTS; i++) begin
      nonempty[i] = (len_r[i] != '0);
    end
  end

  pqrr_sel #(.PORTS(PORTS)) u_sel (
    .map_valid (map_valid_r),
    .map_addr  (map_addr_r),
    .src       (src_r),
    .nonempty  (nonempty),
    .used      (used),
    .start     (start_r),
    .find_hit  (find_hit),
    .find_idx  (find_idx),
    .pick_hit  (pick_hit),
    .pick_idx  (pick_idx)
  );

  // Slot-state read and descriptor addresses.
  always_comb begin
    idx_w      = (state_r == S_MOD) ? pick_idx : sel_r;
    head_w     = head_r[idx_w];
    head_inc   = (head_w == DW'(SLOT_DEPTH - 1)) ? '0 : head_w + DW'(1);
    len_w      = len_r[idx_w];
    addr0      = slot_addr(idx_w, head_w, '0);
    addr1      = slot_addr(idx_w, head_w, DW'(1));
    addr_l     = slot_addr(idx_w, head_w, DW'(len_w));
    markc      = (thr_r != 6'd0) && ((12'(len_w) + 12'd2) >= 12'(thr_r));
    drop       = (12'(len_w) + 12'd1) > lim_w;
    victim_new = !front_r || (len_w <= LW'(1));
    e1         = {rd_data[16] | mark_r, rd_data[15:0]};
  end

  pqrr_ram #(.WIDTH(17), .DEPTH(PORTS * SLOT_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept   = in_tvalid && in_tready;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Next state and descriptor RAM control.
  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == S_IDLE);
    wr_en     = 1'b0;
    wr_addr   = addr_l;
    wr_data   = {1'b0, hd_r};
    rd_en     = 1'b0;
    rd_addr   = addr0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == KIND_DEQ) ? S_MOD : S_FIND;
        end
      end
      S_FIND: begin
        if (src_r == hop_r || !find_hit) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (victim_new) begin
          wr_en     = !drop;
          wr_data   = {markc, hd_r};
          state_nxt = S_DONE;
        end else begin
          wr_en     = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = addr1;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        if (drop_r) begin
          rd_en     = 1'b1;
          state_nxt = S_RD0;
        end else begin
          wr_en     = mark_r;
          wr_addr   = addr1;
          wr_data   = e1;
          state_nxt = S_DONE;
        end
      end
      S_RD0: begin
        wr_en     = 1'b1;
        wr_addr   = addr1;
        wr_data   = rd_data;
        state_nxt = S_DONE;
      end
      S_MOD: begin
        if (32'(start_r) < 32'(used)) begin
          rd_en     = pick_hit;
          state_nxt = pick_hit ? S_DEQ : S_DONE;
        end
      end
      S_DEQ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Slot state, item registers and result assembly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
      turn_r      <= '0;
      for (int i = 0; i < PORTS; i++) begin
        head_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            src_r        <= in_tdata[15:0];
            hd_r         <= in_tdata[31:16];
            start_r      <= turn_r;
            res_status_r <= ST_QUEUED;
            res_handle_r <= '0;
            res_mark_r   <= 1'b0;
            res_len_r    <= '0;
            sel_r        <= '0;
          end
        end
        S_FIND: begin
          if (src_r == hop_r) begin
            res_status_r <= ST_SAMEHOP;
          end else if (!find_hit) begin
            res_status_r <= ST_NOSLOT;
          end else begin
            sel_r                 <= find_idx;
            map_valid_r[find_idx] <= 1'b1;
            map_addr_r[find_idx]  <= src_r;
          end
        end
        S_EVAL: begin
          mark_r    <= markc;
          drop_r    <= drop;
          len_r[sel_r] <= drop ? len_w : len_w + LW'(1);
          res_len_r <= drop ? len_w : len_w + LW'(1);
          if (drop && victim_new) begin
            res_status_r <= ST_DROPPED;
            res_handle_r <= hd_r;
            res_mark_r   <= markc;
          end
        end
        S_RD1: begin
          if (drop_r) begin
            res_status_r <= ST_DROPPED;
            res_handle_r <= e1[15:0];
            res_mark_r   <= e1[16];
          end
        end
        S_RD0: begin
          head_r[sel_r] <= head_inc;
        end
        S_MOD: begin
          if (32'(start_r) >= 32'(used)) begin
            start_r <= SW'(32'(start_r) - 32'(used));
          end else if (!pick_hit) begin
            res_status_r <= ST_EMPTY;
          end else begin
            sel_r         <= pick_idx;
            head_r[pick_idx] <= head_inc;
            len_r[pick_idx]  <= len_w - LW'(1);
            res_len_r     <= len_w - LW'(1);
            res_status_r  <= ST_DEQUEUE;
            if (32'(pick_idx) + 1 == 32'(used)) begin
              turn_r <= '0;
            end else begin
              turn_r <= SW'(32'(pick_idx) + 1);
            end
          end
        end
        S_DEQ: begin
          res_handle_r <= rd_data[15:0];
          res_mark_r   <= rd_data[16];
        end
        default: ;
      endcase
    end
  end

  // Output register: holds one result beat while the next item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status_r;
      out_handle_r <= res_handle_r;
      out_mark_r   <= res_mark_r;
      if (res_status_r == ST_QUEUED || res_status_r == ST_DROPPED ||
          res_status_r == ST_DEQUEUE) begin
        out_slot_r <= 3'(sel_r);
        out_len_r  <= 7'(res_len_r);
      end else begin
        out_slot_r <= 3'd0;
        out_len_r  <= 7'd0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'd0, out_len_r, out_slot_r, out_mark_r, out_handle_r};

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import pqrr_pkg::*;

  localparam int NPORTS = 8;
  localparam int DEPTH  = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  per_input_queue_round_robin_unit #(.PORTS(NPORTS), .SLOT_DEPTH(DEPTH)) DUT (.*);

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] hnd;
    logic        ce;
    logic [2:0]  slot;
    logic [6:0]  len;
  } verdict_t;

  // Shadow copy of the queue state and registers.
  logic [3:0]  sh_active;
  logic [5:0]  sh_limit;
  logic [5:0]  sh_ecn;
  logic        sh_front;
  logic [15:0] sh_hop;
  logic        map_ok [NPORTS];
  logic [15:0] map_addr [NPORTS];
  logic [16:0] store [NPORTS*DEPTH];
  int          head [NPORTS];
  int          qlen [NPORTS];
  int          turn;

  verdict_t    pending[$];
  int          errors = 0;
  int          results_seen = 0;
  int          drops_seen = 0;
  int          marks_seen = 0;
  logic        hold_off = 1'b0;
  logic [15:0] known_src [4];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int cell_at(int s, int idx);
    return s * DEPTH + ((head[s] + idx) % DEPTH);
  endfunction

  function automatic int victim_of(int n);
    if (sh_front) return (n - 1 < 1) ? n - 1 : 1;
    return n - 1;
  endfunction

  function automatic void queue_reset();
    sh_active = 4'd8; sh_limit = 6'd63; sh_ecn = 6'd0; sh_front = 1'b0; sh_hop = 16'd0;
    for (int i = 0; i < NPORTS; i++) begin
      map_ok[i] = 1'b0; map_addr[i] = '0; head[i] = 0; qlen[i] = 0;
    end
    for (int i = 0; i < NPORTS*DEPTH; i++) store[i] = '0;
    turn = 0;
  endfunction

  // Works out the result of one item and updates the shadow state.
  function automatic verdict_t queue_predict(logic kind, logic [15:0] src, logic [15:0] hd);
    verdict_t r;
    int n, s, lim, l, v, j, st;
    logic [16:0] e;
    r = '0;
    n = (sh_active == 0) ? 1 : (sh_active > NPORTS) ? NPORTS : int'(sh_active);
    if (kind == KIND_DEQ) begin
      st = turn % n;
      r.status = ST_EMPTY;
      for (int i = 0; i < n; i++) begin
        j = (st + i) % n;
        if (qlen[j] > 0) begin
          e = store[cell_at(j, 0)];
          head[j] = (head[j] + 1) % DEPTH;
          qlen[j]--;
          turn = (j + 1) % n;
          r.status = ST_DEQUEUE; r.hnd = e[15:0]; r.ce = e[16];
          r.slot = 3'(j); r.len = 7'(qlen[j]);
          return r;
        end
      end
      return r;
    end
    if (src == sh_hop) begin
      r.status = ST_SAMEHOP;
      return r;
    end
    s = NPORTS;
    for (int i = 0; i < n; i++) begin
      if (!map_ok[i] || map_addr[i] == src) begin
        s = i;
        break;
      end
    end
    if (s >= n) begin
      r.status = ST_NOSLOT;
      return r;
    end
    map_ok[s] = 1'b1; map_addr[s] = src;
    lim = (sh_limit > DEPTH - 1) ? DEPTH - 1 : int'(sh_limit);
    l = qlen[s];
    store[cell_at(s, l)] = {1'b0, hd};
    l++;
    if (sh_ecn != 0 && l + 1 >= sh_ecn) store[cell_at(s, victim_of(l))][16] = 1'b1;
    r.status = ST_QUEUED;
    if (l > lim) begin
      v = victim_of(l);
      e = store[cell_at(s, v)];
      if (v == 1 && l > 1) store[cell_at(s, 1)] = store[cell_at(s, 0)];
      if (v + 1 != l || v == 1) head[s] = (head[s] + 1) % DEPTH;
      l--;
      r.status = ST_DROPPED; r.hnd = e[15:0]; r.ce = e[16];
    end
    qlen[s] = l;
    r.slot = 3'(s); r.len = 7'(l);
    return r;
  endfunction

  // Sends one beat, predicting its result when it is taken.
  task automatic send_item(logic kind, logic [15:0] src, logic [15:0] hd);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {hd, src};
    do @(posedge clk); while (!in_tready);
    pending.push_back(queue_predict(kind, src, hd));
  endtask

  task automatic release_bus();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender bursts: random gap after a random number of beats.
  int burst_left = 0;
  task automatic send_bursty(logic kind, logic [15:0] src, logic [15:0] hd);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    send_item(kind, src, hd);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_ACTIVE: sh_active = val[3:0];
      REG_LIMIT:  sh_limit  = val[5:0];
      REG_ECN:    sh_ecn    = val[5:0];
      REG_FRONT:  sh_front  = val[0];
      REG_HOP:    sh_hop    = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(int act, int lim, int ecn, int front, int hop);
    reg_write(REG_ACTIVE, act);
    reg_write(REG_LIMIT, lim);
    reg_write(REG_ECN, ecn);
    reg_write(REG_FRONT, front);
    reg_write(REG_HOP, hop);
  endtask

  // Receiver: a stall pattern of its own, plus a long hold-off on request.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase = (phase + 1) % 64;
      if (hold_off) out_tready <= 1'b0;
      else if (phase < 20) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    verdict_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser; got.hnd = out_tdata[15:0]; got.ce = out_tdata[16];
      got.slot = out_tdata[19:17]; got.len = out_tdata[26:20];
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = pending.pop_front();
        if (got.status == ST_DROPPED) drops_seen++;
        if (got.ce) marks_seen++;
        if (want.status !== got.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (want.hnd !== got.hnd)
          $display("%0t: handle exp %h got %h", $time, want.hnd, got.hnd);
        if (want.ce !== got.ce)
          $display("%0t: mark exp %0d got %0d", $time, want.ce, got.ce);
        if (want.slot !== got.slot)
          $display("%0t: slot exp %0d got %0d", $time, want.slot, got.slot);
        if (want.len !== got.len)
          $display("%0t: length exp %0d got %0d", $time, want.len, got.len);
        if (want !== got) errors++;
        if (out_tdata[31:27] !== 5'd0) begin
          errors++;
          $display("%0t: padding exp 0 got %h", $time, out_tdata[31:27]);
        end
      end
    end
  end

  // Directed: field extremes, both kinds, same hop, no slot, empty queue.
  task automatic test_directed();
    send_item(KIND_DEQ, 16'hFFFF, 16'hFFFF);
    send_item(KIND_ENQ, 16'h0000, 16'h1234);
    send_item(KIND_ENQ, 16'hFFFF, 16'hFFFF);
    send_item(KIND_ENQ, 16'hFFFF, 16'h0000);
    send_item(KIND_ENQ, 16'hAAAA, 16'h5555);
    send_item(KIND_ENQ, 16'h5555, 16'hAAAA);
    for (int i = 0; i < 6; i++) send_item(KIND_ENQ, 16'(16'h0100 + i), 16'(i));
    send_item(KIND_ENQ, 16'h0200, 16'h0BAD);
    for (int i = 0; i < 10; i++) send_item(KIND_DEQ, 16'h0, 16'h0);
    drain();
  endtask

  // Small queues with marking, both victim modes and shrunken slot counts.
  task automatic test_drop_mark(int act, int lim, int ecn, int front, int hop);
    set_regs(act, lim, ecn, front, hop);
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(0, 9) < 6)
        send_bursty(KIND_ENQ, known_src[$urandom_range(0, 3)], 16'($urandom));
      else
        send_bursty(KIND_DEQ, 16'($urandom), 16'($urandom));
    end
    drain();
  endtask

  // Fully random items, including noise sources and the own hop.
  task automatic test_random(int count);
    logic [15:0] src;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: src = sh_hop;
        1, 2: src = 16'($urandom);
        default: src = known_src[$urandom_range(0, 3)];
      endcase
      send_bursty($urandom_range(0, 2) == 0, src, 16'($urandom));
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering beats.
  task automatic test_backpressure();
    hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 40; i++)
        send_item(i % 3 == 2, known_src[i % 4], 16'(i));
    join
    drain();
  endtask

  initial begin
    queue_reset();
    for (int i = 0; i < 4; i++) known_src[i] = 16'($urandom) | 16'h0001;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_drop_mark(8, 3, 2, 0, 16'h0000);
    test_drop_mark(2, 4, 3, 1, 16'hFFFF);
    test_drop_mark(0, 1, 1, 1, 16'h0000);
    test_drop_mark(15, 0, 63, 0, 16'h1234);
    test_drop_mark(1, 63, 0, 1, 16'h0000);
    test_random(200);
    set_regs(3, 5, 4, 0, known_src[0]);
    test_random(200);
    test_backpressure();
    set_regs(8, 63, 0, 0, 16'h0000);
    test_random(80);
    $display("Covered %0d results, %0d drops and %0d marked handles", results_seen,
             drops_seen, marks_seen);
    $display("over several register settings and a long receiver hold-off.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pqrr_pkg.sv
rtl/core/pqrr_ram.sv
rtl/core/pqrr_sel.sv
rtl/core/per_input_queue_round_robin_unit.sv
bench/testbench.sv
